// ----- src/lzss_decompressor_defines.svh -----
// assertion macros shared by the decompressor modules
`ifndef LZSS_DECOMPRESSOR_DEFINES_SVH
`define LZSS_DECOMPRESSOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LZSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LZSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lzsd_pkg.sv -----
// shared constants and command types of the lzss decompressor
`timescale 1ns / 1ps
package lzsd_pkg;

  localparam int WINDOW_BITS_DEF    = 12;
  localparam int LENGTH_BITS_DEF    = 4;
  localparam int MIN_MATCH_SKIP_DEF = 2;

  // tokens announced by one flag byte
  localparam logic [3:0] FLAG_TOKENS = 4'd8;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_MATCH,
    CMD_MARK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic        frame_end;
    logic [7:0]  wr_data;
  } ring_req_t;

endpackage

// ----- src/lzsd_ring.sv -----
// history ring memory with write pointer, fill count and read forwarding
`timescale 1ns / 1ps
`include "lzss_decompressor_defines.svh"
module lzsd_ring import lzsd_pkg::*; #(
  parameter int WINDOW_BITS    = WINDOW_BITS_DEF,
  parameter int LENGTH_BITS    = LENGTH_BITS_DEF,
  parameter int MIN_MATCH_SKIP = MIN_MATCH_SKIP_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ring_req_t              req_i,
  input  logic [WINDOW_BITS-1:0] rd_addr_i,
  output logic [7:0]             rd_data_o
);

  localparam int RingSize = 1 << WINDOW_BITS;
  localparam logic [WINDOW_BITS-1:0] PtrReset =
    WINDOW_BITS'(RingSize - (1 << LENGTH_BITS) - MIN_MATCH_SKIP);
  localparam logic [WINDOW_BITS:0] FillFull = (WINDOW_BITS + 1)'(RingSize);

  logic [7:0]             mem_q [RingSize];
  logic [7:0]             mem_rd_q;
  logic [WINDOW_BITS-1:0] wp_q, wp_d;
  logic [WINDOW_BITS:0]   fill_q, fill_d;
  logic                   fwd_q, hit_q;
  logic [7:0]             fwd_data_q;
  logic [WINDOW_BITS-1:0] rel;
  logic                   hit;
  logic                   fwd;

  // entries written since frame start form one run starting at the reset pointer
  assign rel = rd_addr_i - PtrReset;
  assign hit = ({1'b0, rel} < fill_q);
  assign fwd = req_i.wr_en && (wp_q == rd_addr_i);

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (req_i.frame_end) begin
      wp_d   = PtrReset;
      fill_d = '0;
    end else if (req_i.wr_en) begin
      wp_d = wp_q + 1'b1;
      if (fill_q != FillFull) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= PtrReset;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wp_q] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      mem_rd_q   <= mem_q[rd_addr_i];
      fwd_q      <= fwd;
      fwd_data_q <= req_i.wr_data;
      hit_q      <= hit;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (hit_q ? mem_rd_q : 8'd0);

  `LZSD_ASSERT_NEXT(a_frame_end_rewinds, req_i.frame_end,
                    (wp_q == PtrReset) && (fill_q == '0), "ring not rewound at frame end")
  `LZSD_ASSERT_NOW(a_fill_bounded, 1'b1, fill_q <= FillFull, "fill count beyond ring size")

endmodule

// ----- src/lzsd_parser.sv -----
// token parser: flag bytes, literals and two-byte match references
`timescale 1ns / 1ps
module lzsd_parser import lzsd_pkg::*; #(
  parameter int WINDOW_BITS    = WINDOW_BITS_DEF,
  parameter int LENGTH_BITS    = LENGTH_BITS_DEF,
  parameter int MIN_MATCH_SKIP = MIN_MATCH_SKIP_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   in_frame_last_i,
  output cmd_t                   cmd_o,
  output logic [WINDOW_BITS-1:0] pos_o,
  output logic [$clog2((1 << LENGTH_BITS) + MIN_MATCH_SKIP + 1)-1:0] len_o
);

  localparam int LenW = $clog2((1 << LENGTH_BITS) + MIN_MATCH_SKIP + 1);

  logic [7:0]  flag_q, flag_d;
  logic [3:0]  tokens_q, tokens_d;
  logic        await_q, await_d;
  logic [7:0]  off_q, off_d;
  logic [15:0] pos_full;

  assign pos_full = {8'(in_byte_i >> LENGTH_BITS), off_q};
  assign pos_o    = pos_full[WINDOW_BITS-1:0];
  assign len_o    = LenW'(in_byte_i[LENGTH_BITS-1:0]) + LenW'(MIN_MATCH_SKIP + 1);

  always_comb begin
    flag_d     = flag_q;
    tokens_d   = tokens_q;
    await_d    = await_q;
    off_d      = off_q;
    cmd_o.kind = CMD_NONE;
    cmd_o.data = in_byte_i;
    cmd_o.last = in_frame_last_i;
    if (tokens_q == '0) begin
      flag_d   = in_byte_i;
      tokens_d = FLAG_TOKENS;
    end else if (flag_q[0]) begin
      cmd_o.kind = CMD_LIT;
      flag_d     = flag_q >> 1;
      tokens_d   = tokens_q - 4'd1;
    end else if (!await_q) begin
      off_d   = in_byte_i;
      await_d = 1'b1;
    end else begin
      cmd_o.kind = CMD_MATCH;
      await_d    = 1'b0;
      flag_d     = flag_q >> 1;
      tokens_d   = tokens_q - 4'd1;
    end
    // frame end: empty marker if nothing completes, then parser back to reset
    if (in_frame_last_i) begin
      if (cmd_o.kind == CMD_NONE) begin
        cmd_o.kind = CMD_MARK;
        cmd_o.data = 8'd0;
      end
      flag_d   = '0;
      tokens_d = '0;
      await_d  = 1'b0;
      off_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q   <= '0;
      tokens_q <= '0;
      await_q  <= 1'b0;
      off_q    <= '0;
    end else if (accept_i) begin
      flag_q   <= flag_d;
      tokens_q <= tokens_d;
      await_q  <= await_d;
      off_q    <= off_d;
    end
  end

endmodule

// ----- src/lzsd_copy.sv -----
// copy sequencer, read stage and output register
`timescale 1ns / 1ps
`include "lzss_decompressor_defines.svh"
module lzsd_copy import lzsd_pkg::*; #(
  parameter int WINDOW_BITS    = WINDOW_BITS_DEF,
  parameter int LENGTH_BITS    = LENGTH_BITS_DEF,
  parameter int MIN_MATCH_SKIP = MIN_MATCH_SKIP_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  cmd_t                   cmd_i,
  input  logic [WINDOW_BITS-1:0] pos_i,
  input  logic [$clog2((1 << LENGTH_BITS) + MIN_MATCH_SKIP + 1)-1:0] len_i,
  output logic                   take_o,
  output ring_req_t              ring_req_o,
  output logic [WINDOW_BITS-1:0] ring_addr_o,
  input  logic [7:0]             ring_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   byte_valid_o,
  output logic                   run_last_o,
  output logic                   frame_done_o
);

  localparam int LenW = $clog2((1 << LENGTH_BITS) + MIN_MATCH_SKIP + 1);
  localparam logic [LenW-1:0] LenOne = LenW'(1);

  logic                   busy_q;
  logic [WINDOW_BITS-1:0] addr_q;
  logic [LenW-1:0]        left_q;
  logic                   flast_q;

  logic       s1_v_q, s1_ring_q, s1_bv_q, s1_rl_q, s1_fd_q;
  logic [7:0] s1_data_q;
  logic [7:0] s1_byte;

  logic       out_v_q, out_bv_q, out_rl_q, out_fd_q;
  logic [7:0] out_byte_q;

  logic out_free, s1_move, slot, issue, direct;

  assign out_free = !out_v_q || out_ready_i;
  assign s1_move  = s1_v_q && out_free;
  assign slot     = !s1_v_q || s1_move;
  assign issue    = busy_q && slot;
  assign take_o   = !busy_q && slot;
  assign direct   = cmd_valid_i && ((cmd_i.kind == CMD_LIT) || (cmd_i.kind == CMD_MARK));
  assign s1_byte  = s1_ring_q ? ring_data_i : s1_data_q;

  always_comb begin
    ring_req_o.rd_en     = issue;
    ring_req_o.wr_en     = s1_move && s1_bv_q;
    ring_req_o.frame_end = s1_move && s1_fd_q;
    ring_req_o.wr_data   = s1_byte;
  end
  assign ring_addr_o = addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      addr_q  <= '0;
      left_q  <= '0;
      flast_q <= 1'b0;
    end else if (cmd_valid_i && (cmd_i.kind == CMD_MATCH)) begin
      busy_q  <= 1'b1;
      addr_q  <= pos_i;
      left_q  <= len_i;
      flast_q <= cmd_i.last;
    end else if (issue) begin
      addr_q <= addr_q + 1'b1;
      left_q <= left_q - LenOne;
      if (left_q == LenOne) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (issue || direct) begin
      s1_v_q <= 1'b1;
    end else if (s1_move) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_ring_q <= 1'b1;
      s1_data_q <= 8'd0;
      s1_bv_q   <= 1'b1;
      s1_rl_q   <= (left_q == LenOne);
      s1_fd_q   <= (left_q == LenOne) && flast_q;
    end else if (direct) begin
      s1_ring_q <= 1'b0;
      s1_data_q <= cmd_i.data;
      s1_bv_q   <= (cmd_i.kind == CMD_LIT);
      s1_rl_q   <= 1'b1;
      s1_fd_q   <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_move) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_byte_q <= s1_byte;
      out_bv_q   <= s1_bv_q;
      out_rl_q   <= s1_rl_q;
      out_fd_q   <= s1_fd_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = out_bv_q;
  assign run_last_o   = out_rl_q;
  assign frame_done_o = out_fd_q;

  `LZSD_ASSERT_NOW(a_no_cmd_while_busy, cmd_valid_i, !busy_q, "command during copy")
  `LZSD_ASSERT_NOW(a_busy_has_count, busy_q, left_q != '0, "copy active with zero count")
  `LZSD_ASSERT_NEXT(a_copy_end_run_last, issue && (left_q == LenOne),
                    s1_v_q && s1_rl_q, "last copied byte lacks run_last")

endmodule

// ----- src/lzss_decompressor.sv -----
// lzss decompressor top level: parser, copy sequencer and history ring
// a literal or end marker passes through the read stage and the output register
// the input takes flag, literal and first match bytes without stalling while the output is ready
// the second byte of a match stalls the input while the copy runs, one ring read per byte
// reset: no clearing pass; a fill count makes unwritten ring entries read as zero
// reset and every frame end rewind the write pointer and clear the fill count
`timescale 1ns / 1ps
module lzss_decompressor import lzsd_pkg::*; #(
  parameter int WINDOW_BITS    = WINDOW_BITS_DEF,
  parameter int LENGTH_BITS    = LENGTH_BITS_DEF,
  parameter int MIN_MATCH_SKIP = MIN_MATCH_SKIP_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_frame_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       frame_done_o
);

  localparam int LenW = $clog2((1 << LENGTH_BITS) + MIN_MATCH_SKIP + 1);

  // command from the parser, valid in the cycle its request is taken
  cmd_t                   cmd;
  logic [WINDOW_BITS-1:0] pos;
  logic [LenW-1:0]        len;
  logic                   accept;
  logic                   take;

  // ring access from the copy sequencer
  ring_req_t              ring_req;
  logic [WINDOW_BITS-1:0] ring_addr;
  logic [7:0]             ring_data;

  // input is taken when no copy runs and the read stage has room
  assign in_ready_o = take;
  assign accept     = in_valid_i && take;

  lzsd_parser #(
    .WINDOW_BITS   (WINDOW_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .MIN_MATCH_SKIP(MIN_MATCH_SKIP)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .in_frame_last_i(in_frame_last_i),
    .cmd_o          (cmd),
    .pos_o          (pos),
    .len_o          (len)
  );

  // one byte per cycle while the output is ready: ring read, then output register and ring write-back
  lzsd_copy #(
    .WINDOW_BITS   (WINDOW_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .MIN_MATCH_SKIP(MIN_MATCH_SKIP)
  ) u_copy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (accept),
    .cmd_i       (cmd),
    .pos_i       (pos),
    .len_i       (len),
    .take_o      (take),
    .ring_req_o  (ring_req),
    .ring_addr_o (ring_addr),
    .ring_data_i (ring_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .run_last_o  (run_last_o),
    .frame_done_o(frame_done_o)
  );

  // a read that hits the entry written in the same cycle is forwarded,
  // which keeps overlapping copies exact
  lzsd_ring #(
    .WINDOW_BITS   (WINDOW_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .MIN_MATCH_SKIP(MIN_MATCH_SKIP)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ring_req),
    .rd_addr_i(ring_addr),
    .rd_data_o(ring_data)
  );

endmodule
